// ===== sv/tlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types and constants for the three-level priority queue
// Payload structs, result codes, level codes and the byte classifier.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int LEVELS = 3;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] lvl_t;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // level codes, 0 is highest priority
  localparam lvl_t LVL_HI  = 2'd0;
  localparam lvl_t LVL_MID = 2'd1;
  localparam lvl_t LVL_LO  = 2'd2;

  // bytes sorted to the upper two levels
  localparam byte_t CH_A = 8'h61;
  localparam byte_t CH_B = 8'h62;
  localparam byte_t CH_C = 8'h63;
  localparam byte_t CH_D = 8'h64;
  localparam byte_t CH_F = 8'h66;
  localparam byte_t CH_G = 8'h67;

  typedef struct packed {
    logic  action;
    byte_t char_in;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    byte_t      char_out;
    lvl_t       level;
  } out_t;

  // per-level control from the top and status back
  typedef struct packed {
    logic push;
    logic pop;
  } lvl_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lvl_stat_t;

  function automatic lvl_t level_of(byte_t ch);
    lvl_t l;
    if (ch inside {CH_A, CH_D, CH_G}) begin
      l = LVL_HI;
    end else if (ch inside {CH_B, CH_C, CH_F}) begin
      l = LVL_MID;
    end else begin
      l = LVL_LO;
    end
    return l;
  endfunction

endpackage

// ===== sv/tlpq_cell.sv =====
// ----------------------------------------------------------------------------
// tlpq_cell: one byte slot of a level's shift chain
// Loads the pushed byte when it is the next free slot, else takes the
// neighbor's byte on a pop.
// ----------------------------------------------------------------------------
module tlpq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic              clk,
  input  tlpq_pkg::lvl_ctrl_t ctrl,
  input  logic [CNT_W-1:0]  count,
  input  tlpq_pkg::byte_t   push_data,
  input  tlpq_pkg::byte_t   next_data,
  output tlpq_pkg::byte_t   data
);

  tlpq_pkg::byte_t data_r;
  tlpq_pkg::byte_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push && (count == CNT_W'(IDX))) begin
      data_nxt = push_data;
    end else if (ctrl.pop) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== sv/tlpq_level.sv =====
// ----------------------------------------------------------------------------
// tlpq_level: one priority level as a chain of byte cells
// The oldest byte sits in cell 0; a pop shifts the chain one cell down.
// ----------------------------------------------------------------------------
module tlpq_level #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlpq_pkg::lvl_ctrl_t   ctrl,
  input  tlpq_pkg::byte_t       push_data,
  output tlpq_pkg::byte_t       head,
  output tlpq_pkg::lvl_stat_t   stat
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  tlpq_pkg::byte_t  cell_q [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tlpq_pkg::byte_t nb;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    tlpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .push_data (push_data),
      .next_data (nb),
      .data      (cell_q[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head       = cell_q[0];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));

endmodule

// ===== sv/three_level_priority_queue.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue: strict priority queue of bytes, three levels
// Usage:
//   in_valid/in_stall/in_data carry one operation per transfer: enqueue
//   char_in, or dequeue the oldest byte of the highest non-empty level.
//   'a','d','g' go to level 0, 'b','c','f' to level 1, all else to level 2.
//   out_valid/out_stall/out_data return exactly one result per operation:
//   status (ok, all empty, target full), the byte read and the level.
//   The result is registered: it is valid the cycle after the transfer.
//   Throughput is one operation per cycle while no result is held under
//   out_stall; every operation finishes in the cycle it is taken.
//   While a result is held under out_stall, in_stall is raised and no new
//   operation is taken; the held result does not change.
//   Reset clears every level's fill count and drops any pending result;
//   stored bytes are left as they are and are never read before written.
//   Each level is a chain of QUEUE_DEPTH byte cells, oldest byte in cell 0.
// ----------------------------------------------------------------------------
module three_level_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tlpq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tlpq_pkg::out_t out_data
);

  tlpq_pkg::lvl_ctrl_t ctrl [tlpq_pkg::LEVELS];
  tlpq_pkg::lvl_stat_t stat [tlpq_pkg::LEVELS];
  tlpq_pkg::byte_t     head [tlpq_pkg::LEVELS];

  logic           out_valid_r;
  logic           out_valid_nxt;
  tlpq_pkg::out_t out_data_r;
  tlpq_pkg::out_t out_data_nxt;

  logic           xfer;
  tlpq_pkg::lvl_t enq_lvl;
  tlpq_pkg::lvl_t deq_lvl;
  logic           any_full;
  logic           all_empty;

  // hold the input while an undelivered result sits in the output register
  assign in_stall = out_valid_r && out_stall;
  assign xfer     = in_valid && !in_stall;

  // sort the byte; pick the first non-empty level for a dequeue
  always_comb begin
    enq_lvl   = tlpq_pkg::level_of(in_data.char_in);
    all_empty = stat[0].empty && stat[1].empty && stat[2].empty;
    if (!stat[0].empty) begin
      deq_lvl = tlpq_pkg::LVL_HI;
    end else if (!stat[1].empty) begin
      deq_lvl = tlpq_pkg::LVL_MID;
    end else if (!stat[2].empty) begin
      deq_lvl = tlpq_pkg::LVL_LO;
    end else begin
      deq_lvl = tlpq_pkg::LVL_HI;
    end
    any_full = stat[enq_lvl].full;
  end

  for (genvar k = 0; k < tlpq_pkg::LEVELS; k++) begin : g_lvl
    // push only into a level with room; pop only the chosen level
    assign ctrl[k].push = xfer && (in_data.action == tlpq_pkg::ACT_ENQ)
                          && (enq_lvl == tlpq_pkg::lvl_t'(k)) && !any_full;
    assign ctrl[k].pop  = xfer && (in_data.action == tlpq_pkg::ACT_DEQ)
                          && !all_empty && (deq_lvl == tlpq_pkg::lvl_t'(k));

    tlpq_level #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_level (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[k]),
      .push_data (in_data.char_in),
      .head      (head[k]),
      .stat      (stat[k])
    );
  end

  // build the result for the operation taken this cycle
  always_comb begin
    out_data_nxt = out_data_r;
    if (xfer) begin
      if (in_data.action == tlpq_pkg::ACT_ENQ) begin
        out_data_nxt.status   = any_full ? tlpq_pkg::ST_FULL : tlpq_pkg::ST_OK;
        out_data_nxt.char_out = '0;
        out_data_nxt.level    = enq_lvl;
      end else if (all_empty) begin
        out_data_nxt.status   = tlpq_pkg::ST_EMPTY;
        out_data_nxt.char_out = '0;
        out_data_nxt.level    = tlpq_pkg::LVL_HI;
      end else begin
        out_data_nxt.status   = tlpq_pkg::ST_OK;
        out_data_nxt.char_out = head[deq_lvl];
        out_data_nxt.level    = deq_lvl;
      end
    end
  end

  // advance the output register on a new result; drop valid once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tlpq_result_checker.sv =====
// ----------------------------------------------------------------------------
// tlpq_result_checker: result checker for the three-level priority queue
// Watches both channels, keeps its own copy of the three byte FIFOs, builds
// the expected result of every accepted operation and compares each result
// transfer against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module tlpq_result_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  tlpq_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  tlpq_pkg::out_t out_data,
  output int             fail_count,
  output int             pending_count
);

  tlpq_pkg::byte_t level_store [tlpq_pkg::LEVELS][QUEUE_DEPTH];
  int unsigned     head_slot [tlpq_pkg::LEVELS];
  int unsigned     tail_slot [tlpq_pkg::LEVELS];
  int unsigned     fill [tlpq_pkg::LEVELS];
  tlpq_pkg::out_t  expected_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic tlpq_pkg::lvl_t byte_level(input tlpq_pkg::byte_t b);
    case (b)
      tlpq_pkg::CH_A, tlpq_pkg::CH_D, tlpq_pkg::CH_G: return tlpq_pkg::LVL_HI;
      tlpq_pkg::CH_B, tlpq_pkg::CH_C, tlpq_pkg::CH_F: return tlpq_pkg::LVL_MID;
      default:                                        return tlpq_pkg::LVL_LO;
    endcase
  endfunction

  function automatic int unsigned wrap_next(input int unsigned slot);
    return (slot + 1 >= QUEUE_DEPTH) ? 0 : slot + 1;
  endfunction

  // Apply one operation to the FIFO copies and return the result it gives.
  function automatic tlpq_pkg::out_t apply_operation(input tlpq_pkg::in_t op);
    tlpq_pkg::out_t res;
    tlpq_pkg::lvl_t lv;
    res = '{status: tlpq_pkg::ST_OK, char_out: 8'h00, level: tlpq_pkg::LVL_HI};
    if (op.action == tlpq_pkg::ACT_ENQ) begin
      lv = byte_level(op.char_in);
      res.level = lv;
      if (fill[lv] >= QUEUE_DEPTH) begin
        res.status = tlpq_pkg::ST_FULL;
      end else begin
        level_store[lv][tail_slot[lv]] = op.char_in;
        tail_slot[lv] = wrap_next(tail_slot[lv]);
        fill[lv]++;
      end
    end else begin
      res.status = tlpq_pkg::ST_EMPTY;
      for (int k = 0; k < tlpq_pkg::LEVELS; k++) begin
        if (fill[k] != 0) begin
          res.char_out = level_store[k][head_slot[k]];
          head_slot[k] = wrap_next(head_slot[k]);
          fill[k]--;
          res.level  = tlpq_pkg::lvl_t'(k);
          res.status = tlpq_pkg::ST_OK;
          break;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    tlpq_pkg::out_t want;
    if (!rst_n) begin
      for (int k = 0; k < tlpq_pkg::LEVELS; k++) begin
        head_slot[k] = 0;
        tail_slot[k] = 0;
        fill[k]      = 0;
      end
      expected_results.delete();
    end else begin
      // Check the result transfer first: it belongs to an earlier operation.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: status %0d char %h level %0d",
                                    out_data.status, out_data.char_out, out_data.level));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.char_out != want.char_out)
            report_mismatch($sformatf("char_out %h, expected %h",
                                      out_data.char_out, want.char_out));
          if (out_data.level != want.level)
            report_mismatch($sformatf("level %0d, expected %0d",
                                      out_data.level, want.level));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_operation(in_data));
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the three-level priority queue
// Drives directed and random enqueue/dequeue operations through the block
// under several sender idle and receiver stall mixes; a separate checker
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH       = 16;
  localparam int PHASE_ITEMS = 332;
  localparam int CYCLE_LIMIT = 200000;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  tlpq_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall = 1'b0;
  tlpq_pkg::out_t out_data;

  int fail_count;
  int pending_count;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  three_level_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  tlpq_result_checker #(
    .QUEUE_DEPTH(DEPTH)
  ) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic tlpq_pkg::in_t enq_op(input tlpq_pkg::byte_t b);
    return '{action: tlpq_pkg::ACT_ENQ, char_in: b};
  endfunction

  // Dequeue carries a random byte: the block must ignore it.
  function automatic tlpq_pkg::in_t deq_op();
    return '{action: tlpq_pkg::ACT_DEQ,
             char_in: tlpq_pkg::byte_t'($urandom_range(0, 255))};
  endfunction

  // Pick a random byte that sorts to the given level.
  function automatic tlpq_pkg::byte_t pick_byte(input tlpq_pkg::lvl_t lv);
    tlpq_pkg::byte_t b;
    case (lv)
      tlpq_pkg::LVL_HI: begin
        case ($urandom_range(0, 2))
          0:       b = tlpq_pkg::CH_A;
          1:       b = tlpq_pkg::CH_D;
          default: b = tlpq_pkg::CH_G;
        endcase
      end
      tlpq_pkg::LVL_MID: begin
        case ($urandom_range(0, 2))
          0:       b = tlpq_pkg::CH_B;
          1:       b = tlpq_pkg::CH_C;
          default: b = tlpq_pkg::CH_F;
        endcase
      end
      default: begin
        b = tlpq_pkg::byte_t'($urandom_range(0, 255));
        while (b inside {tlpq_pkg::CH_A, tlpq_pkg::CH_B, tlpq_pkg::CH_C,
                         tlpq_pkg::CH_D, tlpq_pkg::CH_F, tlpq_pkg::CH_G})
          b = tlpq_pkg::byte_t'($urandom_range(0, 255));
      end
    endcase
    return b;
  endfunction

  // Offer one operation, with random idle cycles ahead of it, and hold it
  // until the transfer happens.
  task automatic send_op(input tlpq_pkg::in_t op);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Random traffic in bursts: fill runs aimed at one level to reach the
  // full case, drain runs to empty the levels, and mixed noise.
  task automatic run_random(input int n_items);
    int             done;
    int             kind;
    int             len;
    tlpq_pkg::lvl_t lv;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        lv  = tlpq_pkg::lvl_t'($urandom_range(0, 2));
        len = $urandom_range(1, DEPTH + 4);
        repeat (len) send_op(enq_op(pick_byte(lv)));
      end else if (kind < 7) begin
        len = $urandom_range(1, DEPTH + 4);
        repeat (len) send_op(deq_op());
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(0, 1) == 0)
            send_op(deq_op());
          else if ($urandom_range(0, 1) == 0)
            send_op(enq_op(tlpq_pkg::byte_t'($urandom_range(0, 255))));
          else
            send_op(enq_op(pick_byte(tlpq_pkg::lvl_t'($urandom_range(0, 2)))));
        end
      end
      done += len;
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dequeue on empty, every sorted byte, byte extremes, then
    // drain in priority order and hit empty again.
    send_op(deq_op());
    send_op(enq_op(8'h00));
    send_op(enq_op(tlpq_pkg::CH_B));
    send_op(enq_op(tlpq_pkg::CH_A));
    send_op(enq_op(tlpq_pkg::CH_C));
    send_op(enq_op(8'hFF));
    send_op(enq_op(tlpq_pkg::CH_D));
    send_op(enq_op(tlpq_pkg::CH_F));
    send_op(enq_op(tlpq_pkg::CH_G));
    send_op(enq_op(8'h65));
    send_op(enq_op(8'h60));
    send_op(enq_op(8'h68));
    repeat (11) send_op(deq_op());
    send_op(deq_op());

    // No idling at all.
    idle_pct  = 0;
    stall_pct = 0;
    run_random(PHASE_ITEMS);

    // Sender mostly idle; then pause until every result has come back.
    idle_pct = 79;
    run_random(PHASE_ITEMS);
    wait_drained();

    // Receiver mostly stalling.
    idle_pct  = 0;
    stall_pct = 79;
    run_random(PHASE_ITEMS);

    // Both sides idle now and then.
    idle_pct  = 33;
    stall_pct = 33;
    run_random(PHASE_ITEMS);

    wait_drained();
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
